FILE: sv/cfs_pkg.sv
// Package for the circular FIFO with search: field widths, command and
// status codes, controller states and the controller/datapath interface.
// No dependencies.
`default_nettype none

package cfs_pkg;

    localparam int DATA_W    = 32;
    localparam int CNT_W     = 5;
    localparam int SLOT_W    = 4;
    localparam int DEPTH_DEF = 16;
    localparam int CAP_RESET = 16;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_STATUS = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_FIX,
        S_SCAN
    } t_state;

    typedef enum logic [1:0] {
        DSEL_ZERO,
        DSEL_ONES,
        DSEL_FRONT
    } t_dsel;

    typedef struct packed {
        logic    push;
        logic    pop;
        logic    scan_start;
        logic    scan_next;
        logic    front_load;
        logic    res_load;
        t_status res_status;
        t_dsel   res_dsel;
        logic    res_found;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic match;
        logic last;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: sv/cfs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module cfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/cfs_ctrl.sv
// Controller of the circular FIFO with search: command state machine.
// Depends on cfs_pkg.
`default_nettype none

module cfs_ctrl import cfs_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire logic [1:0] i_cmd,
    input  wire t_dp_stat i_stat,
    output logic          busy,
    output t_dp_cmd       o_dp_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;
    t_cmd   cmd;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign cmd    = t_cmd'(i_cmd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && !i_stat.empty) begin
                    if (cmd == CMD_POP) begin
                        n_state = S_POP_FIX;
                    end else if (cmd == CMD_SEARCH) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_POP_FIX: n_state = S_IDLE;
            S_SCAN: begin
                if (i_stat.match || i_stat.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_dp_cmd            = '0;
        o_dp_cmd.res_status = ST_OK;
        o_dp_cmd.res_dsel   = DSEL_ZERO;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_PUSH: begin
                            o_dp_cmd.push       = !i_stat.full;
                            o_dp_cmd.res_load   = 1'b1;
                            o_dp_cmd.res_status = i_stat.full ? ST_FULL : ST_OK;
                        end
                        CMD_POP: begin
                            o_dp_cmd.pop = !i_stat.empty;
                            if (i_stat.empty) begin
                                o_dp_cmd.res_load   = 1'b1;
                                o_dp_cmd.res_status = ST_EMPTY;
                                o_dp_cmd.res_dsel   = DSEL_ONES;
                            end
                        end
                        CMD_SEARCH: begin
                            o_dp_cmd.scan_start = !i_stat.empty;
                            if (i_stat.empty) begin
                                o_dp_cmd.res_load   = 1'b1;
                                o_dp_cmd.res_status = ST_EMPTY;
                            end
                        end
                        default: begin
                            o_dp_cmd.res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_POP_FIX: begin
                // The popped word is still in the front register this cycle.
                o_dp_cmd.front_load = 1'b1;
                o_dp_cmd.res_load   = 1'b1;
                o_dp_cmd.res_dsel   = DSEL_FRONT;
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    o_dp_cmd.res_load  = 1'b1;
                    o_dp_cmd.res_found = 1'b1;
                end else if (i_stat.last) begin
                    o_dp_cmd.res_load   = 1'b1;
                    o_dp_cmd.res_status = ST_NOT_FOUND;
                end else begin
                    o_dp_cmd.scan_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/cfs_dp.sv
// Datapath of the circular FIFO with search: pointers, count, capacity,
// front/rear shadows, scan registers, result registers and the slot RAM.
// Depends on cfs_pkg and cfs_ram.
`default_nettype none

module cfs_dp import cfs_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic        [CNT_W-1:0]  i_cfg_wdata,
    input  wire logic        [DATA_W-1:0] i_value,
    input  wire t_dp_cmd                  i_dp_cmd,
    output t_dp_stat                      o_stat,
    output logic                          o_done,
    output logic             [1:0]        o_status,
    output logic signed      [DATA_W-1:0] o_data_out,
    output logic             [SLOT_W-1:0] o_found_slot,
    output logic signed      [DATA_W-1:0] o_front_value,
    output logic signed      [DATA_W-1:0] o_rear_value,
    output logic             [CNT_W-1:0]  o_occupancy,
    output logic                          o_is_empty,
    output logic                          o_is_full
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CMP_W   = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
    localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
    localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;
    localparam logic [CNT_W-1:0] CAP_LIM  = CNT_W'(CAP_MAX);
    localparam logic [CNT_W-1:0] CAP_INIT = CNT_W'(CAP_RST);

    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_cap, n_cap;
    logic [DATA_W-1:0] r_front;
    logic [DATA_W-1:0] r_rear;
    logic [PTR_W-1:0]  r_scan_ptr;
    logic [CNT_W-1:0]  r_scan_left;
    logic [DATA_W-1:0] r_key;
    logic [1:0]        r_status;
    logic [DATA_W-1:0] r_data;
    logic [SLOT_W-1:0] r_slot;
    logic              r_done;

    logic [PTR_W-1:0]  push_pos;
    logic [PTR_W-1:0]  head_next;
    logic [PTR_W-1:0]  scan_next;
    logic [PTR_W-1:0]  rd_addr;
    logic              rd_en;
    logic [DATA_W-1:0] rd_data;
    logic [PTR_W+SLOT_W-1:0] scan_ext;

    function automatic logic [PTR_W-1:0] f_next_ptr(
        input logic [PTR_W-1:0] p,
        input logic [CNT_W-1:0] cap
    );
        logic [CMP_W-1:0] p1;
        p1 = CMP_W'(p) + CMP_W'(1);
        return (p1 >= CMP_W'(cap)) ? '0 : p1[PTR_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] f_clamp_cap(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] c;
        c = v;
        if (v == '0) begin
            c = CNT_W'(1);
        end else if (v > CAP_LIM) begin
            c = CAP_LIM;
        end
        return c;
    endfunction

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == r_cap);
    assign o_stat.match = (rd_data == r_key);
    assign o_stat.last  = (r_scan_left == CNT_W'(1));

    assign head_next = f_next_ptr(r_head, r_cap);
    assign scan_next = f_next_ptr(r_scan_ptr, r_cap);
    // An empty FIFO refills from the head slot so the tail never goes stale.
    assign push_pos  = (r_count == '0) ? r_head : f_next_ptr(r_tail, r_cap);

    always_comb begin
        if (i_dp_cmd.pop) begin
            rd_addr = head_next;
        end else if (i_dp_cmd.scan_start) begin
            rd_addr = r_head;
        end else begin
            rd_addr = scan_next;
        end
    end
    assign rd_en = i_dp_cmd.pop || i_dp_cmd.scan_start || i_dp_cmd.scan_next;

    cfs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_dp_cmd.push),
        .i_waddr (push_pos),
        .i_wdata (i_value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_cap   = r_cap;
        if (i_cfg_we) begin
            n_cap   = f_clamp_cap(i_cfg_wdata);
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end else if (i_dp_cmd.push) begin
            n_tail  = push_pos;
            n_count = r_count + CNT_W'(1);
        end else if (i_dp_cmd.pop) begin
            n_head  = head_next;
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_cap   <= CAP_INIT;
            r_done  <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_cap   <= n_cap;
            r_done  <= i_dp_cmd.res_load;
        end
    end

    assign scan_ext = {{SLOT_W{1'b0}}, r_scan_ptr};

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.push) begin
            r_rear <= i_value;
            if (r_count == '0) begin
                r_front <= i_value;
            end
        end
        if (i_dp_cmd.front_load) begin
            r_front <= rd_data;
        end
        if (i_dp_cmd.scan_start) begin
            r_scan_ptr  <= r_head;
            r_scan_left <= r_count;
            r_key       <= i_value;
        end else if (i_dp_cmd.scan_next) begin
            r_scan_ptr  <= scan_next;
            r_scan_left <= r_scan_left - CNT_W'(1);
        end
        if (i_dp_cmd.res_load) begin
            r_status <= i_dp_cmd.res_status;
            r_slot   <= i_dp_cmd.res_found ? scan_ext[SLOT_W-1:0] : '0;
            case (i_dp_cmd.res_dsel)
                DSEL_ONES:  r_data <= '1;
                DSEL_FRONT: r_data <= r_front;
                default:    r_data <= '0;
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_data_out    = r_data;
    assign o_found_slot  = r_slot;
    assign o_front_value = o_stat.empty ? '1 : r_front;
    assign o_rear_value  = o_stat.empty ? '1 : r_rear;
    assign o_occupancy   = r_count;
    assign o_is_empty    = o_stat.empty;
    assign o_is_full     = o_stat.full;

endmodule

`default_nettype wire

FILE: sv/circular_fifo_with_search.sv
// Top level of the circular FIFO with search.
// Depends on cfs_pkg, cfs_ctrl and cfs_dp (which holds cfs_ram).
//
// Usage:
// A command (i_cmd, i_value) transfers at a rising edge with start high and
// busy low. Exactly one result per command appears for one cycle with o_done
// high; the receiver cannot stall it. The result carries status, popped word,
// found slot, and the front/rear words, occupancy and empty/full flags taken
// after the command.
// Command flow:
//   push and status-only: result in the cycle after the transfer, and a new
//     command may transfer in that same cycle, so one command per cycle;
//   pop of a held word: a pass through S_POP_FIX loads the new front word
//     through the slot RAM's registered read port;
//   search of a non-empty FIFO: one slot compared per cycle until a match
//     or the last held slot, through the single RAM read port;
//   pop or search of an empty FIFO: result in the cycle after the transfer.
// The capacity register (i_cfg_we, i_cfg_wdata) may be written only while
// busy is low and no result is pending; a write empties the FIFO. A capacity
// of 0 acts as 1 and one above DEPTH acts as DEPTH.
// Reset empties the FIFO and sets the capacity to 16 (or DEPTH if smaller).
// There is no clearing pass; a slot never written is never shown at an output.
`default_nettype none

module circular_fifo_with_search import cfs_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic        [CNT_W-1:0]  i_cfg_wdata,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic        [1:0]        i_cmd,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic                          o_done,
    output logic             [1:0]        o_status,
    output logic signed      [DATA_W-1:0] o_data_out,
    output logic             [SLOT_W-1:0] o_found_slot,
    output logic signed      [DATA_W-1:0] o_front_value,
    output logic signed      [DATA_W-1:0] o_rear_value,
    output logic             [CNT_W-1:0]  o_occupancy,
    output logic                          o_is_empty,
    output logic                          o_is_full
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    cfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_stat   (dp_stat),
        .busy     (busy),
        .o_dp_cmd (dp_cmd)
    );

    cfs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_value       (i_value),
        .i_dp_cmd      (dp_cmd),
        .o_stat        (dp_stat),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_found_slot  (o_found_slot),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_occupancy   (o_occupancy),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

    // Capacity is at least one, so the FIFO is never both empty and full.
    a_not_empty_and_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_is_empty && o_is_full))
        else $error("FIFO reports empty and full at once");

    // A result is only presented once the controller is back to idle.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while a command is still in progress");

    // An accepted push into a FIFO with room grows the occupancy by one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == CMD_PUSH) && !o_is_full && !i_cfg_we)
        |=> (o_occupancy == CNT_W'($past(o_occupancy) + CNT_W'(1))))
        else $error("push did not raise the occupancy by one");

endmodule

`default_nettype wire
